FILE: src/tcpu_pkg.sv
package tcpu_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int DATA_W        = 8;
    localparam int NUM_REGS      = 4;

    // host operation carried by each input beat
    typedef enum logic [1:0] {
        HOP_WRITE = 2'd0,
        HOP_EXEC  = 2'd1,
        HOP_READ  = 2'd2
    } host_op_t;

    // instruction opcodes, bits 7:4 of the instruction byte
    typedef enum logic [3:0] {
        OPC_ADD   = 4'd0,
        OPC_SUB   = 4'd1,
        OPC_LOAD  = 4'd2,
        OPC_STORE = 4'd3,
        OPC_JMP   = 4'd4,
        OPC_JZ    = 4'd5,
        OPC_AND   = 4'd6,
        OPC_OR    = 4'd7,
        OPC_ADDI  = 4'd8,
        OPC_SUBI  = 4'd9
    } opc_t;

    typedef logic [NUM_REGS-1:0][DATA_W-1:0] byte_arr_t;

    // effects of one executed instruction
    typedef struct packed {
        logic              reg_we;
        logic [1:0]        reg_idx;
        logic [DATA_W-1:0] reg_val;
        logic              st_en;
        logic [1:0]        st_idx;
        logic [DATA_W-1:0] st_val;
        logic [DATA_W-1:0] pc_next;
    } exec_res_t;

endpackage

FILE: src/tiny_8bit_cpu_step.sv
// Tiny 8-bit processor stepped one beat at a time: op 0 writes a memory byte, op 1 runs the
// instruction at the program counter, op 2 reads a memory byte; every beat returns the pc, the
// four registers and the read or fetched byte. A beat is accepted every cycle unless a full execute
// stage is stalled by the output; it passes from the execute stage into the output register. The
// memory read is issued in the accept cycle for use in the execute stage; a new beat's fetch address
// comes from the instruction executing in that same cycle, so the path RAM read data -> decode ->
// next pc -> RAM read address sets the clock. Memory bytes 0..3 are mirrored in flops for LOAD.
// The memory reads as zero after reset through one valid flop per entry, so no clearing pass is
// needed and beats are taken in the first cycle after reset. Addresses wrap modulo MEM_DEPTH.
module tiny_8bit_cpu_step #(
    parameter int MEM_DEPTH = tcpu_pkg::MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] prog_counter,
    output logic [7:0] reg_zero,
    output logic [7:0] reg_one,
    output logic [7:0] reg_two,
    output logic [7:0] reg_three,
    output logic [7:0] read_data,
    output logic [7:0] executed_word
);

    localparam int AW = $clog2(MEM_DEPTH);

    // address wrap table, built at elaboration
    logic [AW-1:0] idx_lut [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_lut
        assign idx_lut[gi] = AW'(gi % MEM_DEPTH);
    end

    // execute stage
    logic                b_vld_reg;
    logic [1:0]          b_op_reg;
    logic [7:0]          b_addr_reg;
    logic [7:0]          b_wdata_reg;
    logic                rd_vld_reg;
    logic                fwd_hit_reg;
    logic [7:0]          fwd_data_reg;

    // architectural state
    logic [7:0]          pc_reg;
    tcpu_pkg::byte_arr_t rf_reg;
    tcpu_pkg::byte_arr_t mem_lo_reg;
    logic [MEM_DEPTH-1:0] mem_vld_reg;

    // output register
    logic                out_vld_reg;
    logic [7:0]          pc_out_reg;
    tcpu_pkg::byte_arr_t rf_out_reg;
    logic [7:0]          rdata_out_reg;
    logic [7:0]          word_out_reg;

    logic                in_fire;
    logic                b_adv;
    logic                b_exec;
    logic [7:0]          b_data;
    logic [7:0]          ram_rdata;
    tcpu_pkg::exec_res_t ex;
    logic [7:0]          pc_next;
    tcpu_pkg::byte_arr_t rf_next;
    logic                wr_en;
    logic [AW-1:0]       wr_idx;
    logic [7:0]          wr_data;
    logic [AW-1:0]       rd_idx;

    assign b_adv    = b_vld_reg & (~out_vld_reg | out_ready);
    assign in_ready = ~b_vld_reg | b_adv;
    assign in_fire  = in_valid & in_ready;
    assign b_exec   = b_vld_reg & (b_op_reg == tcpu_pkg::HOP_EXEC);

    // last write wins over the registered ram read; unwritten entries read zero
    assign b_data = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? ram_rdata : 8'h00);

    tcpu_exec u_exec (
        .word   (b_data),
        .rf     (rf_reg),
        .mem_lo (mem_lo_reg),
        .pc     (pc_reg),
        .res    (ex)
    );

    always_comb
    begin
        pc_next = pc_reg;
        rf_next = rf_reg;
        if (b_exec)
        begin
            pc_next = ex.pc_next;
            if (ex.reg_we)
            begin
                rf_next[ex.reg_idx] = ex.reg_val;
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = idx_lut[b_addr_reg];
        wr_data = b_wdata_reg;
        if (b_adv && b_op_reg == tcpu_pkg::HOP_WRITE)
        begin
            wr_en = 1'b1;
        end
        else if (b_adv && b_exec && ex.st_en)
        begin
            wr_en   = 1'b1;
            wr_idx  = AW'(ex.st_idx);
            wr_data = ex.st_val;
        end
    end

    // fetch uses the pc left by the instruction finishing this cycle
    assign rd_idx = (op == tcpu_pkg::HOP_EXEC) ? idx_lut[pc_next] : idx_lut[address];

    tcpu_ram #(
        .WIDTH (tcpu_pkg::DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (in_fire),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= '0;
            rf_reg      <= '0;
            mem_lo_reg  <= '0;
            mem_vld_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                b_vld_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_vld_reg <= 1'b0;
            end

            if (b_adv)
            begin
                out_vld_reg <= 1'b1;
                pc_reg      <= pc_next;
                rf_reg      <= rf_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (wr_en)
            begin
                mem_vld_reg[wr_idx] <= 1'b1;
                // keep the mirror of bytes 0..3 in step
                if ({1'b0, wr_idx} < (AW + 1)'(4))
                begin
                    mem_lo_reg[wr_idx[1:0]] <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_op_reg     <= op;
            b_addr_reg   <= address;
            b_wdata_reg  <= write_data;
            rd_vld_reg   <= mem_vld_reg[rd_idx];
            fwd_hit_reg  <= wr_en && (wr_idx == rd_idx);
            fwd_data_reg <= wr_data;
        end
        if (b_adv)
        begin
            pc_out_reg    <= pc_next;
            rf_out_reg    <= rf_next;
            rdata_out_reg <= (b_op_reg == tcpu_pkg::HOP_READ) ? b_data : 8'h00;
            word_out_reg  <= b_exec ? b_data : 8'h00;
        end
    end

    assign out_valid     = out_vld_reg;
    assign prog_counter  = pc_out_reg;
    assign reg_zero      = rf_out_reg[0];
    assign reg_one       = rf_out_reg[1];
    assign reg_two       = rf_out_reg[2];
    assign reg_three     = rf_out_reg[3];
    assign read_data     = rdata_out_reg;
    assign executed_word = word_out_reg;

    // a beat enters an occupied execute stage only while that stage drains
    a_accept_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && b_vld_reg |-> b_adv)
        else $error("beat accepted over a stalled execute stage");

    // a result only appears after a beat sat in the execute stage
    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(b_vld_reg))
        else $error("result without an executed beat");

    // pc moves only when an instruction retires
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(b_adv && b_exec) |=> $stable(pc_reg))
        else $error("pc changed without a retired instruction");

endmodule

FILE: src/tcpu_ram.sv
module tcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/tcpu_exec.sv
module tcpu_exec (
    input  logic [7:0]                 word,
    input  tcpu_pkg::byte_arr_t        rf,
    input  tcpu_pkg::byte_arr_t        mem_lo,
    input  logic [7:0]                 pc,
    output tcpu_pkg::exec_res_t        res
);

    logic [3:0] opc;
    logic [1:0] ra;
    logic [1:0] rb;
    logic [7:0] imm;

    assign opc = word[7:4];
    assign ra  = word[3:2];
    assign rb  = word[1:0];
    // 6-bit immediate overlaps opcode low bits and fields a and b
    assign imm = {{2{word[5]}}, word[5:0]};

    always_comb
    begin
        res         = '0;
        res.reg_idx = ra;
        res.reg_val = rf[ra];
        res.st_idx  = rb;
        res.st_val  = rf[ra];
        res.pc_next = pc + 8'd1;
        unique case (tcpu_pkg::opc_t'(opc))
            tcpu_pkg::OPC_ADD:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] + rf[rb];
            end
            tcpu_pkg::OPC_SUB:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] - rf[rb];
            end
            tcpu_pkg::OPC_LOAD:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = mem_lo[rb];
            end
            tcpu_pkg::OPC_STORE:
            begin
                res.st_en = 1'b1;
            end
            tcpu_pkg::OPC_JMP:
            begin
                res.pc_next = {6'd0, rb};
            end
            tcpu_pkg::OPC_JZ:
            begin
                if (rf[ra] == 8'd0)
                begin
                    res.pc_next = {6'd0, rb};
                end
            end
            tcpu_pkg::OPC_AND:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] & rf[rb];
            end
            tcpu_pkg::OPC_OR:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] | rf[rb];
            end
            tcpu_pkg::OPC_ADDI:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] + imm;
            end
            tcpu_pkg::OPC_SUBI:
            begin
                res.reg_we  = 1'b1;
                res.reg_val = rf[ra] - imm;
            end
            default:
            begin
                res.reg_we = 1'b0;
            end
        endcase
    end

endmodule
